>>> sv/orst_pkg.sv
package orst_pkg;

  localparam int CODE_SLOTS = 126;
  localparam int SLOT_W     = $clog2(CODE_SLOTS + 1);
  localparam int REG_NUM    = 256;

  localparam logic [7:0] UNUSED_ENTRY = 8'hFF;
  localparam logic [7:0] CODE_SHORT   = 8'(CODE_SLOTS);
  localparam logic [7:0] CODE_LONG    = 8'(CODE_SLOTS + 1);

  localparam int                RATE_W     = 10;
  localparam logic [RATE_W-1:0] RATE_RESET = 10'd280;

  localparam int MS_SCALE     = 1000;
  localparam int PROD_W       = 26;
  localparam int DIV_PER_CYC  = 2;
  localparam int DIV_CYC      = PROD_W / DIV_PER_CYC;
  localparam int DIV_CNT_W    = $clog2(DIV_CYC);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]        value;
    logic [15:0]       ticks;
    logic [SLOT_W-1:0] slot;
    logic              full;
  } item_t;

endpackage

>>> sv/orst_ram.sv
module orst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> sv/orst_front.sv
module orst_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_reg_address,
  input  logic [7:0]      in_reg_value,
  input  logic [15:0]     in_delay_ticks,
  input  logic            q_full,
  output logic            q_push,
  output orst_pkg::item_t q_item
);

  import orst_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_LOOK = 2'b10
  } fstate_t;

  fstate_t             state_r;
  logic [7:0]          reg_r;
  logic [7:0]          val_r;
  logic [15:0]         ticks_r;
  logic [REG_NUM-1:0]  valid_r;
  logic [SLOT_W-1:0]   fill_r;
  logic [7:0]          raddr;
  logic [SLOT_W-1:0]   rdata;
  logic                accept;
  logic                is_free_reg;
  logic                hit;
  logic                has_room;
  logic                claim;

  assign accept      = in_valid && (state_r == F_IDLE);
  assign in_stall    = (state_r != F_IDLE);
  assign raddr       = (state_r == F_IDLE) ? in_reg_address : reg_r;
  assign is_free_reg = (reg_r == UNUSED_ENTRY);
  assign hit         = !is_free_reg && valid_r[reg_r];
  assign has_room    = (fill_r < SLOT_W'(CODE_SLOTS));
  assign q_push      = (state_r == F_LOOK) && !q_full;
  assign claim       = q_push && !hit && has_room && !is_free_reg;

  always_comb begin
    q_item.value = val_r;
    q_item.ticks = ticks_r;
    q_item.slot  = hit ? rdata : fill_r;
    q_item.full  = !hit && !has_room;
  end

  orst_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(REG_NUM)
  ) u_slot_ram (
    .clk  (clk),
    .we   (claim),
    .waddr(reg_r),
    .wdata(fill_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      valid_r <= '0;
      fill_r  <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            state_r <= F_LOOK;
          end
        end
        F_LOOK: begin
          if (q_push) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
      if (claim) begin
        valid_r[reg_r] <= 1'b1;
        fill_r         <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      reg_r   <= in_reg_address;
      val_r   <= in_reg_value;
      ticks_r <= in_delay_ticks;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= SLOT_W'(CODE_SLOTS))
    else $error("code map fill count beyond slot count");

  a_claim_new: assert property (@(posedge clk) disable iff (!rst_n)
    claim |-> !valid_r[reg_r])
    else $error("claimed a register already in the map");

  a_full_only_when_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_item.full) |-> (fill_r == SLOT_W'(CODE_SLOTS)))
    else $error("map full flagged before all slots claimed");
`endif

endmodule

>>> sv/orst_queue.sv
module orst_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  orst_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output orst_pkg::item_t q_item
);

  import orst_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && !q_valid))
    else $error("queue pushed when full or popped when empty");
`endif

endmodule

>>> sv/orst_back.sv
module orst_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [orst_pkg::RATE_W-1:0] tick_rate,
  input  logic                      q_valid,
  input  orst_pkg::item_t           q_item,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_code,
  output logic [7:0]                out_data,
  output logic                      out_last_of_run,
  output logic                      out_map_full_error,
  output logic [31:0]               out_total_ms,
  output logic [15:0]               out_pair_count
);

  import orst_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_SUM  = 4'b0100,
    B_EMIT = 4'b1000
  } bstate_t;

  bstate_t              state_r, state_nxt;
  item_t                cur_r, cur_nxt;
  logic [PROD_W-1:0]    n_r, n_nxt;
  logic [RATE_W-1:0]    rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pend_err_r, pend_err_nxt;
  logic                 pend_pair_r, pend_pair_nxt;
  logic                 pend_long_r, pend_long_nxt;
  logic                 pend_short_r, pend_short_nxt;
  logic [7:0]           long_dat_r, long_dat_nxt;
  logic [7:0]           short_dat_r, short_dat_nxt;
  logic [31:0]          ms_total_r, ms_total_nxt;
  logic [15:0]          pair_cnt_r, pair_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_code_r, out_code_nxt;
  logic [7:0]           out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_err_r, out_err_nxt;
  logic [31:0]          out_total_r, out_total_nxt;
  logic [15:0]          out_count_r, out_count_nxt;

  logic [RATE_W-1:0]    div_d;
  logic [PROD_W-1:0]    prod;
  logic [RATE_W-1:0]    rem_v;
  logic [RATE_W:0]      rem_sh;
  logic [PROD_W-1:0]    quo_v;
  logic                 out_load;
  logic                 has_long;
  logic [8:0]           short_ms;

  assign div_d    = (tick_rate == '0) ? RATE_W'(1) : tick_rate;
  assign prod     = PROD_W'({10'b0, q_item.ticks} * PROD_W'(MS_SCALE));
  assign out_load = !out_valid_r || !out_stall;
  assign has_long = (n_r > PROD_W'(256));
  assign short_ms = has_long ? {1'b0, n_r[7:0]} : n_r[8:0];

  always_comb begin
    rem_v  = rem_r;
    quo_v  = n_r;
    rem_sh = '0;
    for (int i = 0; i < DIV_PER_CYC; i++) begin
      rem_sh = {rem_v, quo_v[PROD_W-1]};
      quo_v  = {quo_v[PROD_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, div_d}) begin
        rem_v    = RATE_W'(rem_sh - {1'b0, div_d});
        quo_v[0] = 1'b1;
      end else begin
        rem_v = rem_sh[RATE_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    n_nxt          = n_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    pend_err_nxt   = pend_err_r;
    pend_pair_nxt  = pend_pair_r;
    pend_long_nxt  = pend_long_r;
    pend_short_nxt = pend_short_r;
    long_dat_nxt   = long_dat_r;
    short_dat_nxt  = short_dat_r;
    ms_total_nxt   = ms_total_r;
    pair_cnt_nxt   = pair_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_code_nxt   = out_code_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;
    out_total_nxt  = out_total_r;
    out_count_nxt  = out_count_r;
    pop            = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          cur_nxt = q_item;
          if (q_item.full) begin
            pend_err_nxt = 1'b1;
            state_nxt    = B_EMIT;
          end else if (q_item.ticks == '0) begin
            pend_pair_nxt = 1'b1;
            state_nxt     = B_EMIT;
          end else begin
            n_nxt     = prod;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        n_nxt   = quo_v;
        rem_nxt = rem_v;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_CYC - 1)) begin
          state_nxt = B_SUM;
        end
      end
      B_SUM: begin
        ms_total_nxt   = ms_total_r + 32'(n_r);
        pend_pair_nxt  = 1'b1;
        pend_long_nxt  = has_long;
        long_dat_nxt   = n_r[15:8] - 8'd1;
        pend_short_nxt = (short_ms != '0);
        short_dat_nxt  = short_ms[7:0] - 8'd1;
        state_nxt      = B_EMIT;
      end
      B_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = ms_total_r;
          out_err_nxt   = 1'b0;
          priority if (pend_err_r) begin
            out_code_nxt  = 8'd0;
            out_data_nxt  = 8'd0;
            out_last_nxt  = 1'b1;
            out_err_nxt   = 1'b1;
            out_count_nxt = pair_cnt_r;
            pend_err_nxt  = 1'b0;
            state_nxt     = B_IDLE;
          end else if (pend_pair_r) begin
            out_code_nxt  = 8'(cur_r.slot);
            out_data_nxt  = cur_r.value;
            out_last_nxt  = !pend_long_r && !pend_short_r;
            pair_cnt_nxt  = pair_cnt_r + 16'd1;
            out_count_nxt = pair_cnt_r + 16'd1;
            pend_pair_nxt = 1'b0;
            if (!pend_long_r && !pend_short_r) begin
              state_nxt = B_IDLE;
            end
          end else if (pend_long_r) begin
            out_code_nxt  = CODE_LONG;
            out_data_nxt  = long_dat_r;
            out_last_nxt  = !pend_short_r;
            pair_cnt_nxt  = pair_cnt_r + 16'd1;
            out_count_nxt = pair_cnt_r + 16'd1;
            pend_long_nxt = 1'b0;
            if (!pend_short_r) begin
              state_nxt = B_IDLE;
            end
          end else begin
            out_code_nxt   = CODE_SHORT;
            out_data_nxt   = short_dat_r;
            out_last_nxt   = 1'b1;
            pair_cnt_nxt   = pair_cnt_r + 16'd1;
            out_count_nxt  = pair_cnt_r + 16'd1;
            pend_short_nxt = 1'b0;
            state_nxt      = B_IDLE;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      pend_err_r   <= 1'b0;
      pend_pair_r  <= 1'b0;
      pend_long_r  <= 1'b0;
      pend_short_r <= 1'b0;
      ms_total_r   <= '0;
      pair_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_err_r   <= pend_err_nxt;
      pend_pair_r  <= pend_pair_nxt;
      pend_long_r  <= pend_long_nxt;
      pend_short_r <= pend_short_nxt;
      ms_total_r   <= ms_total_nxt;
      pair_cnt_r   <= pair_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    n_r         <= n_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    long_dat_r  <= long_dat_nxt;
    short_dat_r <= short_dat_nxt;
    out_code_r  <= out_code_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
    out_total_r <= out_total_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_code           = out_code_r;
  assign out_data           = out_data_r;
  assign out_last_of_run    = out_last_r;
  assign out_map_full_error = out_err_r;
  assign out_total_ms       = out_total_r;
  assign out_pair_count     = out_count_r;

`ifndef SYNTH
  a_idle_nothing_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE) |-> !(pend_err_r || pend_pair_r || pend_long_r || pend_short_r))
    else $error("back end idle with words still pending");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> out_last_r)
    else $error("map full word not marked last");
`endif

endmodule

>>> sv/opl_register_stream_transcoder_top.sv
// Channel  Direction  Handshake             Word
// in       input      in_valid / in_stall   reg_address, reg_value, delay_ticks
// out      output     out_valid / out_stall code, data, last_of_run, map_full_error,
//                                           total_ms, pair_count
// cfg      input      cfg_wr_en             cfg_wr_data = tick rate in Hz
//
// Front end takes one word at a time: one read of the register-indexed slot RAM.
// Back end: zero delay or map full goes from IDLE straight to EMIT; a nonzero
// delay goes through IDLE, DIV, SUM and EMIT, and EMIT issues up to 3 results;
// the divider in DIV retires two quotient bits a cycle.
// Synchronous reset empties the code map at once and sets the rate to 280 Hz.
// A two-word queue parts front and back; out_stall holds the output register
// and the back end in EMIT, in_stall rises while the front end works on a word.
module opl_register_stream_transcoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_reg_address,
  input  logic [7:0]                  in_reg_value,
  input  logic [15:0]                 in_delay_ticks,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_code,
  output logic [7:0]                  out_data,
  output logic                        out_last_of_run,
  output logic                        out_map_full_error,
  output logic [31:0]                 out_total_ms,
  output logic [15:0]                 out_pair_count,
  input  logic                        cfg_wr_en,
  input  logic [orst_pkg::RATE_W-1:0] cfg_wr_data
);

  import orst_pkg::*;

  logic [RATE_W-1:0] tick_rate_r;
  logic              q_full;
  logic              q_push;
  item_t             push_item;
  logic              q_pop;
  logic              q_valid;
  item_t             q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= RATE_RESET;
    end else if (cfg_wr_en) begin
      tick_rate_r <= cfg_wr_data;
    end
  end

  orst_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_reg_address(in_reg_address),
    .in_reg_value  (in_reg_value),
    .in_delay_ticks(in_delay_ticks),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  orst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  orst_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .tick_rate         (tick_rate_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_code          (out_code),
    .out_data          (out_data),
    .out_last_of_run   (out_last_of_run),
    .out_map_full_error(out_map_full_error),
    .out_total_ms      (out_total_ms),
    .out_pair_count    (out_pair_count)
  );

endmodule

>>> dv/tb_opl_register_stream_transcoder_top.sv
`timescale 1ns / 1ps

module tb_opl_register_stream_transcoder_top;
  import orst_pkg::*;

  typedef struct packed {
    logic [7:0]  addr;
    logic [7:0]  value;
    logic [15:0] ticks;
  } reg_write_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [7:0]  data;
    logic        last;
    logic        err;
    logic [31:0] total;
    logic [15:0] pairs;
  } pair_word_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_reg_address;
  logic [7:0]        in_reg_value;
  logic [15:0]       in_delay_ticks;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_code;
  logic [7:0]        out_data;
  logic              out_last_of_run;
  logic              out_map_full_error;
  logic [31:0]       out_total_ms;
  logic [15:0]       out_pair_count;
  logic              cfg_wr_en;
  logic [RATE_W-1:0] cfg_wr_data;

  reg_write_t        write_backlog [$];
  pair_word_t        pending_pairs [$];
  reg_write_t        next_write;
  reg_write_t        seen_write;
  pair_word_t        got_pair;
  pair_word_t        want_pair;

  logic [7:0]        slot_regs [CODE_SLOTS];
  logic [31:0]       ms_sum;
  logic [15:0]       pair_tally;
  logic [RATE_W-1:0] rate_hz;

  logic              in_taken;
  int                gap_left;
  int                stall_run;
  int                stall_pick;
  int                hold_left;
  bit                hold_req;
  int                mismatch_count;
  int                word_index;

  opl_register_stream_transcoder_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_reg_address     (in_reg_address),
    .in_reg_value       (in_reg_value),
    .in_delay_ticks     (in_delay_ticks),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_code           (out_code),
    .out_data           (out_data),
    .out_last_of_run    (out_last_of_run),
    .out_map_full_error (out_map_full_error),
    .out_total_ms       (out_total_ms),
    .out_pair_count     (out_pair_count),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("mismatch: %s", what);
    end
  endtask

  function automatic void push_pair(input logic [7:0] code, input logic [7:0] data,
                                    input logic last, input logic err);
    pair_word_t p;
    p.code  = code;
    p.data  = data;
    p.last  = last;
    p.err   = err;
    p.total = ms_sum;
    p.pairs = pair_tally;
    pending_pairs.push_back(p);
  endfunction

  function automatic void transcode_write(input reg_write_t w);
    int          slot;
    int          i;
    logic [31:0] ms;
    bit          has_long;
    bit          has_short;
    logic [7:0]  long_data;
    logic [7:0]  short_data;
    slot = -1;
    for (i = 0; i < CODE_SLOTS && slot < 0; i++) begin
      if (slot_regs[i] == w.addr) begin
        slot = i;
      end else if (slot_regs[i] == UNUSED_ENTRY) begin
        slot_regs[i] = w.addr;
        slot = i;
      end
    end
    if (slot < 0) begin
      push_pair(8'd0, 8'd0, 1'b1, 1'b1);
      return;
    end
    has_long   = 1'b0;
    has_short  = 1'b0;
    long_data  = 8'd0;
    short_data = 8'd0;
    if (w.ticks != 16'd0) begin
      ms = (32'(w.ticks) * 32'd1000) / ((rate_hz == '0) ? 32'd1 : 32'(rate_hz));
      ms_sum = ms_sum + ms;
      if (ms > 32'd256) begin
        has_long  = 1'b1;
        long_data = 8'((ms >> 8) - 32'd1);
        ms        = ms & 32'hFF;
      end
      if (ms != 32'd0) begin
        has_short  = 1'b1;
        short_data = 8'(ms - 32'd1);
      end
    end
    pair_tally = pair_tally + 16'd1;
    push_pair(8'(slot), w.value, !has_long && !has_short, 1'b0);
    if (has_long) begin
      pair_tally = pair_tally + 16'd1;
      push_pair(CODE_LONG, long_data, !has_short, 1'b0);
    end
    if (has_short) begin
      pair_tally = pair_tally + 16'd1;
      push_pair(CODE_SHORT, short_data, 1'b1, 1'b0);
    end
  endfunction

  function automatic logic [15:0] pick_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 16'd0;
    else if (r < 70) return 16'($urandom_range(1, 300));
    else if (r < 88) return 16'($urandom_range(301, 5000));
    else return 16'($urandom_range(0, 65535));
  endfunction

  function automatic reg_write_t random_write(input bit wide);
    reg_write_t w;
    int         r;
    r = $urandom_range(0, 99);
    if (wide || r >= 90) begin
      w.addr = 8'($urandom_range(0, 255));
    end else if (r < 5) begin
      w.addr = UNUSED_ENTRY;
    end else begin
      w.addr = 8'($urandom_range(0, 47));
    end
    w.value = 8'($urandom_range(0, 255));
    w.ticks = pick_ticks();
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  task automatic add_write(input logic [7:0] a, input logic [7:0] v, input logic [15:0] t);
    reg_write_t w;
    w.addr  = a;
    w.value = v;
    w.ticks = t;
    write_backlog.push_back(w);
  endtask

  task automatic set_tick_rate(input logic [RATE_W-1:0] rate);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic settle();
    while (write_backlog.size() != 0 || in_valid || pending_pairs.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
  endtask

  // input side
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the offered word
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (write_backlog.size() != 0) begin
      next_write = write_backlog.pop_front();
      in_valid       <= 1'b1;
      in_reg_address <= next_write.addr;
      in_reg_value   <= next_write.value;
      in_delay_ticks <= next_write.ticks;
      gap_left       <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output side back-pressure
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 500;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (stall_run > 0) begin
      stall_run = stall_run - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(0, 7);
      end else if (stall_pick < 80) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else if (stall_pick < 92) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(3, 29);
      end else begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(40, 150);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_wr_en) begin
        rate_hz = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        seen_write.addr  = in_reg_address;
        seen_write.value = in_reg_value;
        seen_write.ticks = in_delay_ticks;
        transcode_write(seen_write);
      end
      if (out_valid && !out_stall) begin
        got_pair.code  = out_code;
        got_pair.data  = out_data;
        got_pair.last  = out_last_of_run;
        got_pair.err   = out_map_full_error;
        got_pair.total = out_total_ms;
        got_pair.pairs = out_pair_count;
        if (pending_pairs.size() == 0) begin
          flag_mismatch($sformatf("word %0d unexpected: code %0d data %0d", word_index,
                                  got_pair.code, got_pair.data));
        end else begin
          want_pair = pending_pairs.pop_front();
          if (got_pair !== want_pair) begin
            flag_mismatch($sformatf(
              "word %0d got %0d/%0d/%0b/%0b/%0d/%0d want %0d/%0d/%0b/%0b/%0d/%0d",
              word_index, got_pair.code, got_pair.data, got_pair.last, got_pair.err,
              got_pair.total, got_pair.pairs, want_pair.code, want_pair.data,
              want_pair.last, want_pair.err, want_pair.total, want_pair.pairs));
          end
        end
        word_index++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[opl_register_stream_transcoder_top] ERROR");
    $finish;
  end

  initial begin
    logic [RATE_W-1:0] phase_rate [8];
    int                p;
    int                i;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_reg_address = 8'd0;
    in_reg_value   = 8'd0;
    in_delay_ticks = 16'd0;
    out_stall      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_taken       = 1'b0;
    gap_left       = 0;
    stall_run      = 0;
    hold_left      = 0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    word_index     = 0;
    ms_sum         = 32'd0;
    pair_tally     = 16'd0;
    rate_hz        = RATE_RESET;
    for (i = 0; i < CODE_SLOTS; i++) begin
      slot_regs[i] = UNUSED_ENTRY;
    end
    phase_rate[0] = RATE_RESET;
    phase_rate[1] = RATE_W'($urandom_range(100, 1000));
    phase_rate[2] = 10'd1000;
    phase_rate[3] = 10'd100;
    phase_rate[4] = 10'd1023;
    phase_rate[5] = 10'd0;
    phase_rate[6] = RATE_W'($urandom_range(100, 1000));
    phase_rate[7] = 10'd1;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_tick_rate(10'd1000);
    add_write(8'h00, 8'h00, 16'd0);
    add_write(8'hFF, 8'hFF, 16'd0);
    add_write(8'hFF, 8'h00, 16'd256);
    add_write(8'h01, 8'hAA, 16'd256);
    add_write(8'h01, 8'h55, 16'd257);
    add_write(8'h02, 8'h0F, 16'd512);
    add_write(8'h03, 8'hF0, 16'hFFFF);
    add_write(8'h00, 8'h01, 16'd1);
    add_write(8'hFE, 8'h80, 16'd1000);
    settle();
    set_tick_rate(10'd1023);
    add_write(8'h04, 8'h00, 16'd1);
    add_write(8'h04, 8'h33, 16'd1023);
    add_write(8'h80, 8'hCC, 16'hFFFF);
    settle();
    set_tick_rate(10'd0);
    add_write(8'h05, 8'h7F, 16'hFFFF);
    add_write(8'h05, 8'h01, 16'd1);
    settle();
    set_tick_rate(10'd1);
    add_write(8'h06, 8'h00, 16'h8000);
    add_write(8'h06, 8'hFF, 16'h0100);
    settle();
    set_tick_rate(10'd100);
    add_write(8'h07, 8'h5A, 16'hFFFF);
    add_write(8'h40, 8'hA5, 16'd3);
    settle();

    for (p = 0; p < 8; p++) begin
      set_tick_rate(phase_rate[p]);
      repeat (60) write_backlog.push_back(random_write(p >= 4));
      if (p == 2) begin
        hold_req = 1'b1;
      end
      settle();
    end

    if (mismatch_count == 0 && pending_pairs.size() == 0) begin
      $display("[opl_register_stream_transcoder_top] OK");
    end else begin
      $display("[opl_register_stream_transcoder_top] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/orst_pkg.sv
sv/orst_ram.sv
sv/orst_front.sv
sv/orst_queue.sv
sv/orst_back.sv
sv/opl_register_stream_transcoder_top.sv
dv/tb_opl_register_stream_transcoder_top.sv
